// ----- rtl/tsqs_pkg.sv -----
// Shared types and constants for the timed step queue sequencer.
// No dependencies; compile first.
package tsqs_pkg;

  // Command codes carried by an input item
  typedef enum logic [2:0] {
    CMD_ENQUEUE = 3'd0,
    CMD_TICK    = 3'd1,
    CMD_RESUME  = 3'd2,
    CMD_SKIP    = 3'd3,
    CMD_RESET   = 3'd4
  } cmd_t;

  // Step kinds; any other code plays as a plain animation
  localparam logic [1:0] KIND_WAIT     = 2'd1;
  localparam logic [1:0] KIND_CALLBACK = 2'd2;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned FRAMES_W = 8;
  localparam int unsigned TAG_W    = 8;

  localparam logic [TIME_W-1:0] DEFAULT_DURATION = 32'd500;
  localparam logic [TIME_W-1:0] WAIT_DURATION    = 32'hFFFF_FFFF;

  // One queued step as held in the step store
  typedef struct packed {
    logic [TIME_W-1:0]   duration;
    logic [PERIOD_W-1:0] period;
    logic [FRAMES_W-1:0] frames;
    logic [1:0]          kind;
    logic                start_hook;
    logic                finish_hook;
    logic [TAG_W-1:0]    tag;
  } step_entry_t;

  // Request to the serial divider
  typedef struct packed {
    logic                start;
    logic [TIME_W-1:0]   dividend;
    logic [PERIOD_W-1:0] divisor;
  } div_req_t;

  // Divider result
  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/timed_step_queue_sequencer.sv -----
// Timed step queue sequencer: ring queue of timed steps with a serial frame divider.
// One item at a time; the 32-step frame division of the head step dominates the time to a
// result, and a retire adds a second store read. A new item is taken only once the last
// result is registered, and not while the result side stalls.
// Synchronous active-high rst clears pointers, count, flags and start time; the step
// store is not cleared. Depends on tsqs_pkg, tsqs_ram, tsqs_div.
module timed_step_queue_sequencer #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         command,
  input  logic [31:0]                        now_ms,
  input  logic [1:0]                         step_kind,
  input  logic [31:0]                        step_duration,
  input  logic [7:0]                         frame_total,
  input  logic [15:0]                        frame_period,
  input  logic                               start_hook,
  input  logic                               finish_hook,
  input  logic [7:0]                         step_tag,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               accepted,
  output logic                               finished_valid,
  output logic [7:0]                         finished_tag,
  output logic                               started_valid,
  output logic [7:0]                         started_tag,
  output logic                               is_playing,
  output logic                               is_waiting,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   queued,
  output logic [7:0]                         frame_now
);
  import tsqs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = $bits(step_entry_t);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_WRITE  = 9'b000000010,
    S_FETCH  = 9'b000000100,
    S_LOOK   = 9'b000001000,
    S_TICK   = 9'b000010000,
    S_RETIRE = 9'b000100000,
    S_FRAME  = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t            state;
  cmd_t              cmd_r;
  logic [TIME_W-1:0] now_r;
  step_entry_t       in_entry;
  step_entry_t       head_q;
  step_entry_t       ram_q;
  logic [ENT_W-1:0]  ram_rdata;

  logic [PTR_W-1:0]  head_ptr;
  logic [PTR_W-1:0]  tail_ptr;
  logic [CNT_W-1:0]  fill_count;
  logic              playing;
  logic              waiting;
  logic [TIME_W-1:0] start_time;
  logic              begin_pending;

  logic              acc_r;
  logic              fin_v;
  logic [TAG_W-1:0]  fin_tag;
  logic              st_v;
  logic [TAG_W-1:0]  st_tag;
  logic [TAG_W-1:0]  frame_r;
  logic [TIME_W-1:0] dur_r;

  logic              full;
  logic              ram_we;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] len_calc;
  logic [23:0]       frame_product;
  logic [FRAMES_W-1:0] last_frame;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_ready = (state == S_IDLE);
  assign full     = (fill_count == CNT_W'(QUEUE_DEPTH));
  assign ram_we   = (state == S_WRITE) && (cmd_r == CMD_ENQUEUE) && !full;
  assign ram_q    = step_entry_t'(ram_rdata);
  assign elapsed  = now_r - start_time;
  assign last_frame = head_q.frames - 1'b1;

  // step store; read port always follows the head
  tsqs_ram #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_ptr),
    .wdata (ENT_W'(in_entry)),
    .raddr (head_ptr),
    .rdata (ram_rdata)
  );

  // serial divider for the current frame
  tsqs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    div_req.start    = (state == S_FRAME) && playing && (head_q.frames > 8'd1)
                       && (head_q.period != '0);
    div_req.dividend = elapsed;
    div_req.divisor  = head_q.period;
  end

  // duration of the head step as read from the store
  always_comb begin
    frame_product = 24'(ram_q.frames) * 24'(ram_q.period);
    if (ram_q.duration != '0) begin
      len_calc = ram_q.duration;
    end else if (ram_q.kind == KIND_WAIT) begin
      len_calc = WAIT_DURATION;
    end else if (ram_q.kind == KIND_CALLBACK) begin
      len_calc = 32'd1;
    end else if (ram_q.frames != '0 && ram_q.period != '0) begin
      len_calc = TIME_W'(frame_product);
    end else begin
      len_calc = DEFAULT_DURATION;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head_ptr      <= '0;
      tail_ptr      <= '0;
      fill_count    <= '0;
      playing       <= 1'b0;
      waiting       <= 1'b0;
      start_time    <= '0;
      begin_pending <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // a new result in S_DONE takes over the register in the same cycle
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r                <= cmd_t'(command);
            now_r                <= now_ms;
            in_entry.duration    <= step_duration;
            in_entry.period      <= frame_period;
            in_entry.frames      <= frame_total;
            in_entry.kind        <= step_kind;
            in_entry.start_hook  <= start_hook;
            in_entry.finish_hook <= finish_hook;
            in_entry.tag         <= step_tag;
            acc_r   <= 1'b0;
            fin_v   <= 1'b0;
            fin_tag <= '0;
            st_v    <= 1'b0;
            st_tag  <= '0;
            frame_r <= '0;
            state   <= S_WRITE;
          end
        end
        S_WRITE: begin
          // enqueue stores at the tail; store write happens this cycle
          if (cmd_r == CMD_ENQUEUE && !full) begin
            tail_ptr      <= (tail_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ptr + 1'b1;
            fill_count    <= fill_count + 1'b1;
            acc_r         <= 1'b1;
            begin_pending <= !playing;
          end
          state <= S_FETCH;
        end
        S_FETCH: begin
          state <= S_LOOK;
        end
        S_LOOK: begin
          head_q <= ram_q;
          dur_r  <= len_calc;
          if (begin_pending) begin
            // start the new head step
            begin_pending <= 1'b0;
            playing       <= 1'b1;
            start_time    <= now_r;
            waiting       <= (ram_q.kind == KIND_WAIT);
            if (ram_q.start_hook) begin
              st_v   <= 1'b1;
              st_tag <= ram_q.tag;
            end
            state <= S_FRAME;
          end else begin
            case (cmd_r)
              CMD_TICK: begin
                state <= (playing && !waiting) ? S_TICK : S_FRAME;
              end
              CMD_RESUME: begin
                if (waiting) begin
                  waiting <= 1'b0;
                  state   <= S_RETIRE;
                end else begin
                  state <= S_FRAME;
                end
              end
              CMD_SKIP: begin
                state <= (playing && !waiting) ? S_RETIRE : S_FRAME;
              end
              CMD_RESET: begin
                head_ptr   <= '0;
                tail_ptr   <= '0;
                fill_count <= '0;
                playing    <= 1'b0;
                waiting    <= 1'b0;
                start_time <= '0;
                state      <= S_FRAME;
              end
              default: begin
                state <= S_FRAME;
              end
            endcase
          end
        end
        S_TICK: begin
          state <= (elapsed >= dur_r) ? S_RETIRE : S_FRAME;
        end
        S_RETIRE: begin
          if (head_q.finish_hook) begin
            fin_v   <= 1'b1;
            fin_tag <= head_q.tag;
          end
          head_ptr   <= (head_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ptr + 1'b1;
          fill_count <= fill_count - 1'b1;
          if (fill_count == CNT_W'(1)) begin
            playing <= 1'b0;
            waiting <= 1'b0;
            state   <= S_FRAME;
          end else begin
            begin_pending <= 1'b1;
            state         <= S_FETCH;
          end
        end
        S_FRAME: begin
          state <= div_req.start ? S_DIV : S_DONE;
        end
        S_DIV: begin
          // clamp quotient to the last frame
          if (div_rsp.done) begin
            if (div_rsp.quotient[TIME_W-1:FRAMES_W] != '0
                || div_rsp.quotient[FRAMES_W-1:0] > last_frame) begin
              frame_r <= last_frame;
            end else begin
              frame_r <= div_rsp.quotient[FRAMES_W-1:0];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            accepted       <= acc_r;
            finished_valid <= fin_v;
            finished_tag   <= fin_tag;
            started_valid  <= st_v;
            started_tag    <= st_tag;
            is_playing     <= playing;
            is_waiting     <= waiting;
            queued         <= fill_count;
            frame_now      <= frame_r;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // count never exceeds the queue depth
  assert property (@(posedge clk) disable iff (rst) fill_count <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  // between items a step is active exactly when the queue holds one
  assert property (@(posedge clk) disable iff (rst)
                   state == S_IDLE |-> playing == (fill_count != '0))
    else $error("playing flag disagrees with fill count");

  // waiting only on an active step
  assert property (@(posedge clk) disable iff (rst) waiting |-> playing)
    else $error("waiting without an active step");

  // event tags are zero when no event is reported
  assert property (@(posedge clk) disable iff (rst)
                   out_valid |-> (finished_valid || finished_tag == '0)
                                 && (started_valid || started_tag == '0))
    else $error("event tag without event");

  // a successful enqueue leaves at least one step queued
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && accepted |-> queued != '0)
    else $error("accepted enqueue with empty queue");

endmodule

// ----- rtl/tsqs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tsqs_ram #(
  parameter int WIDTH = 68,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tsqs_div.sv -----
// Restoring serial divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
// Depends on tsqs_pkg. Divisor must be nonzero.
module tsqs_div (
  input  logic               clk,
  input  logic               rst,
  input  tsqs_pkg::div_req_t req,
  output tsqs_pkg::div_rsp_t rsp
);
  import tsqs_pkg::*;

  localparam int CNT_W = $clog2(TIME_W);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [TIME_W-1:0]   dq;
  logic [PERIOD_W-1:0] rem;
  logic [PERIOD_W-1:0] dvs;
  logic                done;

  logic [PERIOD_W:0]   shifted;
  logic [PERIOD_W:0]   diff;
  logic                ge;

  // one quotient bit per cycle
  always_comb begin
    shifted = {rem, dq[TIME_W-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dq   <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= ge ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
        dq  <= {dq[TIME_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(TIME_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench for timed_step_queue_sequencer: directed and random step commands,
// each result checked against a scoreboard that tracks the step queue.
// Depends on tsqs_pkg and the sequencer RTL; reads no files.
module tb;
  import tsqs_pkg::*;

  localparam int DEPTH          = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_ITEMS   = 1320;
  localparam int PHASE_LEN      = 120;

  // command codes the block ignores, and step kinds the package leaves unnamed
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic [1:0] KIND_PLAIN      = 2'd0;
  localparam logic [1:0] KIND_SPARE      = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] now_ms;
    logic [1:0]  kind;
    logic [31:0] duration;
    logic [7:0]  frames;
    logic [15:0] period;
    logic        start_hook;
    logic        finish_hook;
    logic [7:0]  tag;
  } step_cmd_t;

  typedef struct packed {
    logic       accepted;
    logic       fin_valid;
    logic [7:0] fin_tag;
    logic       start_valid;
    logic [7:0] start_tag;
    logic       playing;
    logic       waiting;
    logic [4:0] queued;
    logic [7:0] frame;
  } step_report_t;

  // Tracks the step queue and holds the reports still owed by the block
  class step_queue_scoreboard;
    step_entry_t  slots [DEPTH];
    int           head = 0;
    int           tail = 0;
    int           fill = 0;
    bit           playing = 1'b0;
    bit           waiting = 1'b0;
    logic [31:0]  t0 = '0;
    step_report_t rpt;
    step_report_t expected_reports [$];
    int           errors = 0;
    int           checked = 0;
    int           refused = 0;
    int           both_events = 0;
    int           deep_frames = 0;

    // playing time of a stored step
    function logic [31:0] step_length(step_entry_t e);
      logic [31:0] n, p;
      n = 32'(e.frames);
      p = 32'(e.period);
      if (e.duration != '0) return e.duration;
      if (e.kind == KIND_WAIT) return WAIT_DURATION;
      if (e.kind == KIND_CALLBACK) return 32'd1;
      if (n != 0 && p != 0) return n * p;
      return DEFAULT_DURATION;
    endfunction

    function void launch_head(logic [31:0] now);
      if (fill == 0) begin
        playing = 1'b0;
        waiting = 1'b0;
        return;
      end
      playing = 1'b1;
      t0      = now;
      waiting = (slots[head].kind == KIND_WAIT);
      if (slots[head].start_hook) begin
        rpt.start_valid = 1'b1;
        rpt.start_tag   = slots[head].tag;
      end
    endfunction

    function void retire_head(logic [31:0] now);
      if (fill == 0) return;
      if (slots[head].finish_hook) begin
        rpt.fin_valid = 1'b1;
        rpt.fin_tag   = slots[head].tag;
      end
      head = (head + 1) % DEPTH;
      fill--;
      launch_head(now);
    endfunction

    // frame index of the head step, clamped to its last frame
    function logic [7:0] frame_at(logic [31:0] now);
      logic [31:0] n, p, f, elapsed;
      if (!playing || fill == 0) return '0;
      n = 32'(slots[head].frames);
      p = 32'(slots[head].period);
      if (n <= 1 || p == 0) return '0;
      elapsed = now - t0;
      f = elapsed / p;
      if (f > n - 1) f = n - 1;
      return f[7:0];
    endfunction

    // apply one accepted command and queue the report it must produce
    function void predict_command(step_cmd_t c);
      logic [31:0] elapsed;
      rpt = '0;
      elapsed = c.now_ms - t0;
      case (c.command)
        CMD_ENQUEUE: begin
          if (fill < DEPTH) begin
            slots[tail] = '{duration: c.duration, period: c.period, frames: c.frames,
                            kind: c.kind, start_hook: c.start_hook,
                            finish_hook: c.finish_hook, tag: c.tag};
            tail = (tail + 1) % DEPTH;
            fill++;
            rpt.accepted = 1'b1;
            if (!playing) launch_head(c.now_ms);
          end else begin
            refused++;
          end
        end
        CMD_TICK: begin
          if (playing && !waiting && fill != 0 && elapsed >= step_length(slots[head]))
            retire_head(c.now_ms);
        end
        CMD_RESUME: begin
          if (waiting) begin
            waiting = 1'b0;
            retire_head(c.now_ms);
          end
        end
        CMD_SKIP: begin
          if (playing && !waiting) retire_head(c.now_ms);
        end
        CMD_RESET: begin
          head    = 0;
          tail    = 0;
          fill    = 0;
          playing = 1'b0;
          waiting = 1'b0;
          t0      = '0;
        end
        default: ;
      endcase
      rpt.playing = playing;
      rpt.waiting = waiting;
      rpt.queued  = fill[4:0];
      rpt.frame   = frame_at(c.now_ms);
      if (rpt.fin_valid && rpt.start_valid) both_events++;
      if (rpt.frame != '0) deep_frames++;
      expected_reports.push_back(rpt);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    // compare one result from the block with the oldest owed report
    function void compare_report(step_report_t got);
      step_report_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: result expected none, got %h", $time, got);
        return;
      end
      want = expected_reports.pop_front();
      checked++;
      check_field("accepted", 32'(want.accepted), 32'(got.accepted));
      check_field("finished_valid", 32'(want.fin_valid), 32'(got.fin_valid));
      check_field("finished_tag", 32'(want.fin_tag), 32'(got.fin_tag));
      check_field("started_valid", 32'(want.start_valid), 32'(got.start_valid));
      check_field("started_tag", 32'(want.start_tag), 32'(got.start_tag));
      check_field("is_playing", 32'(want.playing), 32'(got.playing));
      check_field("is_waiting", 32'(want.waiting), 32'(got.waiting));
      check_field("queued", 32'(want.queued), 32'(got.queued));
      check_field("frame_now", 32'(want.frame), 32'(got.frame));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  command = '0;
  logic [31:0] now_ms = '0;
  logic [1:0]  step_kind = '0;
  logic [31:0] step_duration = '0;
  logic [7:0]  frame_total = '0;
  logic [15:0] frame_period = '0;
  logic        start_hook = 1'b0;
  logic        finish_hook = 1'b0;
  logic [7:0]  step_tag = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        accepted;
  logic        finished_valid;
  logic [7:0]  finished_tag;
  logic        started_valid;
  logic [7:0]  started_tag;
  logic        is_playing;
  logic        is_waiting;
  logic [4:0]  queued;
  logic [7:0]  frame_now;

  step_queue_scoreboard sb;
  bit          calm = 1'b0;
  int          fill_bias = 45;
  logic [31:0] clock_ms = 32'd1000;
  int          idle_cycles = 0;
  int          items_sent = 0;

  timed_step_queue_sequencer #(.QUEUE_DEPTH(DEPTH)) u_top (.*);

  always #5 clk = ~clk;

  // sender gap: mostly none or short, a few long
  function automatic int pick_send_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic step_cmd_t make_step(logic [2:0] cmd, logic [31:0] at, logic [1:0] kind,
                                          logic [31:0] dur, logic [7:0] frames,
                                          logic [15:0] period, logic sh, logic fh,
                                          logic [7:0] tag);
    return '{cmd, at, kind, dur, frames, period, sh, fh, tag};
  endfunction

  function automatic logic [2:0] pick_command();
    int r;
    logic [2:0] spare;
    r = $urandom_range(0, 99);
    if (sb.waiting && r < 35) return CMD_RESUME;
    r = $urandom_range(0, 99);
    if (r < fill_bias) return CMD_ENQUEUE;
    if (r < 91) return CMD_TICK;
    if (r < 95) return CMD_SKIP;
    if (r < 97) return CMD_RESUME;
    if (r < 98) return CMD_RESET;
    spare = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    return spare;
  endfunction

  // random step content; time moves forward, with rare jumps and random stamps
  function automatic step_cmd_t random_step(logic [2:0] cmd);
    step_cmd_t c;
    int r;
    if (cmd == CMD_TICK) begin
      if ($urandom_range(0, 19) == 0) clock_ms += $urandom_range(0, 3000);
      else clock_ms += $urandom_range(0, 25);
    end else if ($urandom_range(0, 3) == 0) begin
      clock_ms += $urandom_range(0, 10);
    end
    c.command = cmd;
    c.now_ms  = ($urandom_range(0, 49) == 0) ? $urandom() : clock_ms;
    c.kind    = 2'($urandom_range(KIND_PLAIN, KIND_SPARE));
    r = $urandom_range(0, 19);
    if (r < 10) c.duration = '0;
    else if (r < 17) c.duration = $urandom_range(1, 60);
    else if (r < 19) c.duration = $urandom();
    else c.duration = WAIT_DURATION;
    c.frames      = 8'(($urandom_range(0, 9) != 0) ? $urandom_range(0, 12)
                                                   : $urandom_range(0, 255));
    c.period      = 16'(($urandom_range(0, 9) != 0) ? $urandom_range(0, 20)
                                                    : $urandom_range(0, 65535));
    c.start_hook  = 1'($urandom_range(0, 1));
    c.finish_hook = 1'($urandom_range(0, 1));
    c.tag         = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // present one item and hold it until the block takes it
  task automatic send_step(input step_cmd_t c);
    int gap;
    gap = pick_send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= c.command;
    now_ms        <= c.now_ms;
    step_kind     <= c.kind;
    step_duration <= c.duration;
    frame_total   <= c.frames;
    frame_period  <= c.period;
    start_hook    <= c.start_hook;
    finish_hook   <= c.finish_hook;
    step_tag      <= c.tag;
    do @(posedge clk); while (!in_ready);
    sb.predict_command(c);
    items_sent++;
  endtask

  // result side back-pressure
  initial begin : result_stall
    int n;
    wait (rst == 1'b0);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // collect results
  always @(posedge clk) begin : collect
    step_report_t got;
    if (!rst && out_valid && out_ready) begin
      got.accepted    = accepted;
      got.fin_valid   = finished_valid;
      got.fin_tag     = finished_tag;
      got.start_valid = started_valid;
      got.start_tag   = started_tag;
      got.playing     = is_playing;
      got.waiting     = is_waiting;
      got.queued      = queued;
      got.frame       = frame_now;
      sb.compare_report(got);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int k;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // fill every slot: timed animation, wait, callback, endless step, then random
    send_step(make_step(CMD_ENQUEUE, 32'd1000, KIND_PLAIN, '0, 8'd4, 16'd10, 1'b1, 1'b1, 8'hA5));
    send_step(make_step(CMD_ENQUEUE, 32'd1001, KIND_WAIT, '0, '0, '0, 1'b1, 1'b1, 8'h01));
    send_step(make_step(CMD_ENQUEUE, 32'd1002, KIND_CALLBACK, '0, 8'd3, 16'hFFFF,
                        1'b1, 1'b0, 8'hFF));
    send_step(make_step(CMD_ENQUEUE, 32'hFFFF_FFFF, KIND_SPARE, 32'hFFFF_FFFF, 8'd255, 16'd1,
                        1'b0, 1'b1, 8'h00));
    for (k = 4; k < DEPTH; k++) send_step(random_step(CMD_ENQUEUE));
    // full queue refuses
    send_step(make_step(CMD_ENQUEUE, 32'd1010, KIND_PLAIN, 32'd5, '0, '0, 1'b1, 1'b1, 8'h5A));
    // mid-step frame, then retire with next start in the same result
    send_step(make_step(CMD_TICK, 32'd1015, KIND_PLAIN, '0, '0, '0, 1'b0, 1'b0, '0));
    send_step(make_step(CMD_TICK, 32'd1040, KIND_PLAIN, '0, '0, '0, 1'b0, 1'b0, '0));
    // wait step ignores ticks until resumed
    send_step(make_step(CMD_TICK, 32'd5000, KIND_PLAIN, '0, '0, '0, 1'b0, 1'b0, '0));
    send_step(make_step(CMD_RESUME, 32'd5000, KIND_PLAIN, '0, '0, '0, 1'b0, 1'b0, '0));
    // callback lasts one ms; endless step clamps at its last frame and is skipped
    send_step(make_step(CMD_TICK, 32'd5001, KIND_PLAIN, '0, '0, '0, 1'b0, 1'b0, '0));
    send_step(make_step(CMD_TICK, 32'd6001, KIND_PLAIN, '0, '0, '0, 1'b0, 1'b0, '0));
    send_step(make_step(CMD_SKIP, 32'd6001, KIND_PLAIN, '0, '0, '0, 1'b0, 1'b0, '0));
    // reset command, ignored code, and commands with nothing to act on
    send_step(make_step(CMD_RESET, 32'd6002, KIND_PLAIN, '0, '0, '0, 1'b0, 1'b0, '0));
    send_step(make_step(CMD_SPARE_LAST, 32'd6003, KIND_PLAIN, '0, '0, '0, 1'b0, 1'b0, '0));
    send_step(make_step(CMD_TICK, 32'd7000, KIND_PLAIN, '0, '0, '0, 1'b0, 1'b0, '0));
    send_step(make_step(CMD_RESUME, 32'd7000, KIND_PLAIN, '0, '0, '0, 1'b0, 1'b0, '0));
    send_step(make_step(CMD_SKIP, 32'd7000, KIND_PLAIN, '0, '0, '0, 1'b0, 1'b0, '0));

    // random phases: vary queue pressure, idling and the time base
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % PHASE_LEN == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 2))
          0: fill_bias = 20;
          1: fill_bias = 45;
          default: fill_bias = 70;
        endcase
        if ($urandom_range(0, 3) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
      end
      send_step(random_step(pick_command()));
    end
    in_valid <= 1'b0;

    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d step commands; %0d enqueues refused on a full queue.",
             items_sent, sb.refused);
    $display("Compared %0d results (%0d with retire and start, %0d mid-frame), %0d mismatches.",
             sb.checked, sb.both_events, sb.deep_frames, sb.errors);
    if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
